// File: rtl/itc_pkg.sv
// shared types and constants for the interval timer channel
`default_nettype none

package itc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int BYTE_BITS   = 8;
    localparam int WIDE_BITS   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [1:0] PORT_DATA = 2'd0;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // control word fields
    localparam logic [1:0] SEL_THIS_COUNTER = 2'd0;
    localparam logic [1:0] ACCESS_LATCH     = 2'd0;
    localparam logic [2:0] MODE_ONE_SHOT    = 3'd0;
    localparam logic [1:0] MODE_RATE_LOW    = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [1:0]           port_addr;
        logic [BYTE_BITS-1:0] write_data;
    } t_itc_in;

    typedef struct packed {
        logic [BYTE_BITS-1:0] read_data;
        logic                 out_level;
        logic                 terminal_event;
        logic                 is_counting;
    } t_itc_out;

    // pipeline flow control shared by the two register stages
    typedef struct packed {
        logic load;
        logic advance;
    } t_itc_flow;

endpackage

`default_nettype wire

// File: rtl/itc_in_stage.sv
// input register stage of the interval timer channel
`default_nettype none

module itc_in_stage
    import itc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_itc_flow i_flow,
    input  wire t_itc_in   i_beat,
    output logic           o_valid,
    output t_itc_in        o_beat
);

    logic    r_valid;
    logic    n_valid;
    t_itc_in r_beat;

    always_comb begin
        n_valid = r_valid;
        if (i_flow.load) begin
            n_valid = 1'b1;
        end else if (i_flow.advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_flow.load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// File: rtl/itc_core.sv
// counter channel state and per-beat update logic
`default_nettype none

module itc_core
    import itc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_itc_in i_beat,
    output t_itc_out     o_result
);

    logic                 r_periodic, n_periodic;
    t_count               r_reload, n_reload;
    t_count               r_count, n_count;
    t_count               r_latched, n_latched;
    logic                 r_latch_held, n_latch_held;
    logic                 r_write_high, n_write_high;
    logic                 r_read_high, n_read_high;
    logic [BYTE_BITS-1:0] r_pending_low, n_pending_low;
    logic                 r_pin, n_pin;
    logic                 r_running, n_running;

    logic [BYTE_BITS-1:0] rd_byte;
    logic                 term;
    logic [2:0]           mode;
    t_count               dec;
    t_count               rd_src;
    logic [WIDE_BITS-1:0] rd_wide;
    t_count               load_val;

    assign mode     = i_beat.write_data[3:1];
    assign dec      = r_count - COUNT_WIDTH'(1);
    assign rd_src   = r_latch_held ? r_latched : r_count;
    assign rd_wide  = WIDE_BITS'(rd_src);
    assign load_val = COUNT_WIDTH'({i_beat.write_data, r_pending_low});

    always_comb begin
        n_periodic    = r_periodic;
        n_reload      = r_reload;
        n_count       = r_count;
        n_latched     = r_latched;
        n_latch_held  = r_latch_held;
        n_write_high  = r_write_high;
        n_read_high   = r_read_high;
        n_pending_low = r_pending_low;
        n_pin         = r_pin;
        n_running     = r_running;
        rd_byte       = '0;
        term          = 1'b0;

        case (t_opcode'(i_beat.opcode))
            OP_TICK: begin
                if (r_running) begin
                    if (r_periodic) begin
                        if (r_count == COUNT_WIDTH'(1)) begin
                            n_count = r_reload;
                            n_pin   = 1'b1;
                            term    = 1'b1;
                        end else begin
                            n_count = dec;
                            n_pin   = (dec != COUNT_WIDTH'(1));
                        end
                    end else begin
                        n_count = dec;
                        if (dec == '0) begin
                            n_pin     = 1'b1;
                            n_running = 1'b0;
                            term      = 1'b1;
                        end
                    end
                end
            end
            OP_WRITE: begin
                if (i_beat.port_addr == PORT_CTRL) begin
                    if (i_beat.write_data[7:6] == SEL_THIS_COUNTER) begin
                        if (i_beat.write_data[5:4] == ACCESS_LATCH) begin
                            if (!r_latch_held) begin
                                n_latched    = r_count;
                                n_latch_held = 1'b1;
                                n_read_high  = 1'b0;
                            end
                        end else begin
                            n_running    = 1'b0;
                            n_latch_held = 1'b0;
                            n_read_high  = 1'b0;
                            n_write_high = 1'b0;
                            if (mode[1:0] == MODE_RATE_LOW) begin
                                n_periodic = 1'b1;
                                n_pin      = 1'b1;
                            end else begin
                                n_periodic = 1'b0;
                                n_pin      = (mode != MODE_ONE_SHOT);
                            end
                        end
                    end
                end else if (i_beat.port_addr == PORT_DATA) begin
                    if (!r_write_high) begin
                        n_pending_low = i_beat.write_data;
                        n_write_high  = 1'b1;
                        if (!r_periodic) begin
                            n_running = 1'b0;
                            n_pin     = 1'b0;
                        end
                    end else begin
                        n_write_high = 1'b0;
                        n_reload     = load_val;
                        if (!r_periodic) begin
                            n_count   = load_val;
                            n_running = 1'b1;
                            n_pin     = 1'b0;
                        end else if (!r_running) begin
                            n_count   = load_val;
                            n_running = 1'b1;
                            n_pin     = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if (i_beat.port_addr == PORT_DATA) begin
                    if (r_read_high) begin
                        rd_byte      = rd_wide[2*BYTE_BITS-1:BYTE_BITS];
                        n_read_high  = 1'b0;
                        n_latch_held = 1'b0;
                    end else begin
                        rd_byte     = rd_wide[BYTE_BITS-1:0];
                        n_read_high = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic    <= 1'b0;
            r_reload      <= '0;
            r_count       <= '0;
            r_latched     <= '0;
            r_latch_held  <= 1'b0;
            r_write_high  <= 1'b0;
            r_read_high   <= 1'b0;
            r_pending_low <= '0;
            r_pin         <= 1'b0;
            r_running     <= 1'b0;
        end else if (i_fire) begin
            r_periodic    <= n_periodic;
            r_reload      <= n_reload;
            r_count       <= n_count;
            r_latched     <= n_latched;
            r_latch_held  <= n_latch_held;
            r_write_high  <= n_write_high;
            r_read_high   <= n_read_high;
            r_pending_low <= n_pending_low;
            r_pin         <= n_pin;
            r_running     <= n_running;
        end
    end

    assign o_result.read_data      = rd_byte;
    assign o_result.out_level      = n_pin;
    assign o_result.terminal_event = term;
    assign o_result.is_counting    = n_running;

endmodule

`default_nettype wire

// File: rtl/itc_out_stage.sv
// result register stage of the interval timer channel
`default_nettype none

module itc_out_stage
    import itc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_itc_flow i_flow,
    input  wire t_itc_out  i_result,
    input  wire logic      i_ready,
    output logic           o_valid,
    output t_itc_out       o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_itc_out r_beat;

    always_comb begin
        n_valid = r_valid;
        if (i_flow.advance) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_flow.advance) begin
            r_beat <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// File: rtl/interval_timer_channel_unit.sv
// top level of the 8254-style binary counter channel
//
// one input beat is a clock tick, a bus write or a bus read (opcode,
// port_addr, write_data); every input beat yields exactly one result beat
// (read_data, out_level, terminal_event, is_counting), in order
// both channels are valid/ready; a beat moves when valid and ready are high
// a beat accepted into the input register moves on to the result register
// once the result register is free, and shows there as a valid result
// throughput: one beat per cycle while the receiver takes results, set by
// the single update pass between the input register and the result register
// the result register and the input register form two stages, so a new
// beat is taken while a finished result waits for the receiver
// when the receiver stalls, the result holds; one more beat can sit in the
// input register, after which o_in_ready drops until the result is taken
// synchronous active-low reset empties both stages and returns the channel
// to one-shot mode, stopped, count zero, output pin low, no latch held
// and both byte orders at the low byte
`default_nettype none

module interval_timer_channel_unit
    import itc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_itc_in  i_in_beat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_itc_out      o_out_beat
);

    // pipeline flow control
    t_itc_flow flow;
    logic      stage_valid;
    t_itc_in   stage_beat;
    t_itc_out  result;

    // the held beat moves on whenever the result register is free or emptying
    assign flow.advance = stage_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready   = !stage_valid || flow.advance;
    assign flow.load    = i_in_valid && o_in_ready;

    // input register
    itc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (flow),
        .i_beat  (i_in_beat),
        .o_valid (stage_valid),
        .o_beat  (stage_beat)
    );

    // channel state, updated once per beat as it leaves the input register
    itc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (flow.advance),
        .i_beat   (stage_beat),
        .o_result (result)
    );

    // result register
    itc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (flow),
        .i_result (result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_beat   (o_out_beat)
    );

    // terminal count always leaves the output pin high
    a_term_pin_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.terminal_event |-> o_out_beat.out_level)
        else $error("terminal count with output pin low");

    // back-pressure only when both stages are full and the result is stalled
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> stage_valid && o_out_valid && !i_out_ready)
        else $error("input stalled with a free stage");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !stage_valid)
        else $error("beat pending after reset");

endmodule

`default_nettype wire
